### rtl/wsfr_pkg.sv
// shared types and constants of the websocket frame receiver
package wsfr_pkg;

    // parse phases
    localparam logic [2:0] PH_HDR0   = 3'd0;
    localparam logic [2:0] PH_HDR1   = 3'd1;
    localparam logic [2:0] PH_EXT    = 3'd2;
    localparam logic [2:0] PH_MASK   = 3'd3;
    localparam logic [2:0] PH_DATA   = 3'd4;
    localparam logic [2:0] PH_CLOSED = 3'd5;

    // frame opcodes
    localparam logic [3:0] OP_CONT   = 4'h0;
    localparam logic [3:0] OP_TEXT   = 4'h1;
    localparam logic [3:0] OP_BINARY = 4'h2;
    localparam logic [3:0] OP_CLOSE  = 4'h8;
    localparam logic [3:0] OP_PING   = 4'h9;
    localparam logic [3:0] OP_PONG   = 4'hA;

    // 7-bit length codes that announce an extended length
    localparam logic [6:0] LEN_CODE_16 = 7'd126;
    localparam logic [6:0] LEN_CODE_64 = 7'd127;

    // event kinds
    localparam logic [1:0] KIND_DATA  = 2'd0;
    localparam logic [1:0] KIND_PONG  = 2'd1;
    localparam logic [1:0] KIND_CLOSE = 2'd2;
    localparam logic [1:0] KIND_ERROR = 2'd3;

    // error codes
    localparam logic [2:0] ERR_NONE       = 3'd0;
    localparam logic [2:0] ERR_STREAM_END = 3'd1;
    localparam logic [2:0] ERR_FRAME_LEN  = 3'd2;
    localparam logic [2:0] ERR_MSG_LEN    = 3'd3;
    localparam logic [2:0] ERR_OPCODE     = 3'd4;

    // configuration register indexes
    localparam logic [7:0] REG_MAX_FRAME   = 8'd0;
    localparam logic [7:0] REG_MAX_MESSAGE = 8'd1;

    localparam logic [31:0] MAX_FRAME_RESET   = 32'd1048576;
    localparam logic [31:0] MAX_MESSAGE_RESET = 32'd16777216;

    typedef struct packed {
        logic [1:0] event_kind;
        logic       has_byte;
        logic [7:0] out_byte;
        logic       ends_unit;
        logic       text_message;
        logic [2:0] error_code;
        logic       now_closed;
    } wsfr_result_t;

endpackage

### rtl/wsfr_parse.sv
// frame parser: header decode, length checks, unmasking and result formation
module wsfr_parse
    import wsfr_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         advance,
    input  logic [7:0]   byte_value,
    input  logic         stream_ended,
    input  logic [31:0]  max_frame_payload,
    input  logic [31:0]  max_message_bytes,
    output logic         res_valid,
    output wsfr_result_t res,
    output logic         closed
);

    logic [2:0]  phase_reg, phase_next;
    logic        fin_reg, fin_next;
    logic [3:0]  op_reg, op_next;
    logic        mask_reg, mask_next;
    logic [63:0] length_reg, length_next;
    logic [2:0]  hdr_cnt_reg, hdr_cnt_next;
    logic [7:0]  key_reg [4];
    logic [7:0]  key_next [4];
    logic [1:0]  key_idx_reg, key_idx_next;
    logic [63:0] left_reg, left_next;
    logic [31:0] asm_cnt_reg, asm_cnt_next;
    logic        asm_text_reg, asm_text_next;

    logic [6:0]  len_code;
    logic [63:0] len_eff;
    logic        mask_eff;
    logic        do_len_known;
    logic        do_begin;
    logic        do_finish;
    logic        fin_hb;
    logic [7:0]  fin_byte;
    logic [7:0]  plain;
    logic        bounded;
    logic        deliver;
    logic [31:0] room;

    assign closed = (phase_reg == PH_CLOSED);

    always_comb
    begin
        phase_next    = phase_reg;
        fin_next      = fin_reg;
        op_next       = op_reg;
        mask_next     = mask_reg;
        length_next   = length_reg;
        hdr_cnt_next  = hdr_cnt_reg;
        key_next      = key_reg;
        key_idx_next  = key_idx_reg;
        left_next     = left_reg;
        asm_cnt_next  = asm_cnt_reg;
        asm_text_next = asm_text_reg;
        res_valid     = 1'b0;
        res           = '0;
        len_code      = byte_value[6:0];
        len_eff       = length_reg;
        mask_eff      = mask_reg;
        do_len_known  = 1'b0;
        do_begin      = 1'b0;
        do_finish     = 1'b0;
        fin_hb        = 1'b0;
        fin_byte      = 8'd0;
        plain         = byte_value;
        bounded       = 1'b0;
        deliver       = 1'b0;
        room          = max_message_bytes - asm_cnt_reg;

        if (advance && phase_reg != PH_CLOSED)
        begin
            if (stream_ended)
            begin
                phase_next     = PH_CLOSED;
                res_valid      = 1'b1;
                res.event_kind = KIND_ERROR;
                res.error_code = ERR_STREAM_END;
                res.now_closed = 1'b1;
            end
            else
            begin
                case (phase_reg)
                    PH_HDR0:
                    begin
                        fin_next   = byte_value[7];
                        op_next    = byte_value[3:0];
                        phase_next = PH_HDR1;
                    end
                    PH_HDR1:
                    begin
                        mask_next = byte_value[7];
                        mask_eff  = byte_value[7];
                        if (len_code == LEN_CODE_16 || len_code == LEN_CODE_64)
                        begin
                            length_next  = 64'd0;
                            hdr_cnt_next = (len_code == LEN_CODE_16) ? 3'd1 : 3'd7;
                            phase_next   = PH_EXT;
                        end
                        else
                        begin
                            len_eff      = {57'd0, len_code};
                            length_next  = len_eff;
                            do_len_known = 1'b1;
                        end
                    end
                    PH_EXT:
                    begin
                        len_eff     = {length_reg[55:0], byte_value};
                        length_next = len_eff;
                        if (hdr_cnt_reg == 3'd0)
                            do_len_known = 1'b1;
                        else
                            hdr_cnt_next = hdr_cnt_reg - 3'd1;
                    end
                    PH_MASK:
                    begin
                        key_next[hdr_cnt_reg[1:0]] = byte_value;
                        if (hdr_cnt_reg >= 3'd3)
                        begin
                            hdr_cnt_next = 3'd0;
                            do_begin     = 1'b1;
                        end
                        else
                            hdr_cnt_next = hdr_cnt_reg + 3'd1;
                    end
                    PH_DATA:
                    begin
                        plain        = mask_reg ? (byte_value ^ key_reg[key_idx_reg])
                                                : byte_value;
                        key_idx_next = key_idx_reg + 2'd1;
                        left_next    = left_reg - 64'd1;
                        if (left_reg == 64'd1)
                        begin
                            do_finish = 1'b1;
                            fin_hb    = 1'b1;
                            fin_byte  = plain;
                        end
                        else
                        begin
                            res.has_byte = 1'b1;
                            res.out_byte = plain;
                            case (op_reg)
                                OP_CONT, OP_TEXT, OP_BINARY:
                                begin
                                    res_valid        = 1'b1;
                                    res.event_kind   = KIND_DATA;
                                    res.text_message = asm_text_reg;
                                end
                                OP_CLOSE:
                                begin
                                    res_valid      = 1'b1;
                                    res.event_kind = KIND_CLOSE;
                                end
                                OP_PING:
                                begin
                                    res_valid      = 1'b1;
                                    res.event_kind = KIND_PONG;
                                end
                                default:
                                    res_valid = 1'b0;
                            endcase
                        end
                    end
                    default:
                        phase_next = PH_CLOSED;
                endcase

                // declared length is complete
                if (do_len_known)
                begin
                    if (len_eff > {32'd0, max_frame_payload})
                    begin
                        phase_next     = PH_CLOSED;
                        res_valid      = 1'b1;
                        res.event_kind = KIND_ERROR;
                        res.error_code = ERR_FRAME_LEN;
                        res.now_closed = 1'b1;
                    end
                    else
                    begin
                        hdr_cnt_next = 3'd0;
                        if (mask_eff)
                            phase_next = PH_MASK;
                        else
                            do_begin = 1'b1;
                    end
                end

                // header and, for a masked frame, mask key complete
                if (do_begin)
                begin
                    bounded = (op_reg == OP_CONT) ||
                              ((op_reg == OP_TEXT || op_reg == OP_BINARY) &&
                               (!fin_reg || asm_cnt_reg != 32'd0));
                    if (op_reg == OP_TEXT)
                        asm_text_next = 1'b1;
                    if (op_reg == OP_BINARY)
                        asm_text_next = 1'b0;
                    if (bounded && (asm_cnt_reg > max_message_bytes ||
                                    len_eff > {32'd0, room}))
                    begin
                        phase_next     = PH_CLOSED;
                        res_valid      = 1'b1;
                        res.event_kind = KIND_ERROR;
                        res.error_code = ERR_MSG_LEN;
                        res.now_closed = 1'b1;
                    end
                    else
                    begin
                        key_idx_next = 2'd0;
                        left_next    = len_eff;
                        if (len_eff == 64'd0)
                            do_finish = 1'b1;
                        else
                            phase_next = PH_DATA;
                    end
                end

                // last payload byte or empty payload
                if (do_finish)
                begin
                    phase_next   = PH_HDR0;
                    res          = '0;
                    res.has_byte = fin_hb;
                    res.out_byte = fin_byte;
                    case (op_reg)
                        OP_CONT, OP_TEXT, OP_BINARY:
                        begin
                            if (op_reg != OP_CONT)
                                deliver = fin_reg;
                            else
                                deliver = fin_reg && (asm_cnt_reg != 32'd0);
                            if (deliver)
                                asm_cnt_next = 32'd0;
                            else
                                asm_cnt_next = asm_cnt_reg + length_next[31:0];
                            res_valid        = fin_hb || deliver;
                            res.event_kind   = KIND_DATA;
                            res.ends_unit    = deliver;
                            res.text_message = asm_text_next;
                        end
                        OP_CLOSE:
                        begin
                            phase_next     = PH_CLOSED;
                            res_valid      = 1'b1;
                            res.event_kind = KIND_CLOSE;
                            res.ends_unit  = 1'b1;
                            res.now_closed = 1'b1;
                        end
                        OP_PING:
                        begin
                            res_valid      = 1'b1;
                            res.event_kind = KIND_PONG;
                            res.ends_unit  = 1'b1;
                        end
                        OP_PONG:
                            res_valid = 1'b0;
                        default:
                        begin
                            phase_next     = PH_CLOSED;
                            res_valid      = 1'b1;
                            res.has_byte   = 1'b0;
                            res.out_byte   = 8'd0;
                            res.event_kind = KIND_ERROR;
                            res.error_code = ERR_OPCODE;
                            res.now_closed = 1'b1;
                        end
                    endcase
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_HDR0;
            fin_reg      <= 1'b0;
            op_reg       <= OP_CONT;
            mask_reg     <= 1'b0;
            hdr_cnt_reg  <= 3'd0;
            key_idx_reg  <= 2'd0;
            left_reg     <= 64'd0;
            asm_cnt_reg  <= 32'd0;
            asm_text_reg <= 1'b0;
        end
        else
        begin
            phase_reg    <= phase_next;
            fin_reg      <= fin_next;
            op_reg       <= op_next;
            mask_reg     <= mask_next;
            hdr_cnt_reg  <= hdr_cnt_next;
            key_idx_reg  <= key_idx_next;
            left_reg     <= left_next;
            asm_cnt_reg  <= asm_cnt_next;
            asm_text_reg <= asm_text_next;
        end
    end

    // length and mask key are always written before they are read
    always_ff @(posedge clk)
    begin
        length_reg <= length_next;
        key_reg    <= key_next;
    end

endmodule

### rtl/websocket_frame_receiver_top.sv
// top level of the websocket frame receiver: ports, config registers, result register
//
// usage
// - input stream (s_*): one link byte per transfer in s_tdata; s_tuser flags that
//   the link ended instead of delivering a byte
// - output stream (m_*): at most one result per input byte; payload bytes of data,
//   ping and close frames leave unmasked, errors leave as a single error result
// - config channel (cfg_*): always ready; index 0 writes the largest frame payload,
//   index 1 the largest reassembled message size; write only while the block is idle
// - output timing: a result is registered and appears on m_* in the cycle after the byte that causes it
// - throughput: one byte per cycle while no held result stalls the input, set by the single
//   header/payload decode path between the input handshake and the result register
// - s_tready is high while the result register is empty or being drained, so a
//   new byte is taken in the same cycle the held result leaves
// - when the receiver stalls (m_tready low with a result held), s_tready drops and
//   the held result stays unchanged
// - reset returns the parser to the first header byte, clears the reassembly count
//   and loads the default limits (1048576 and 16777216)
// - after an error or a close frame the channel is closed: input is still taken
//   but gives no result until the next reset
module websocket_frame_receiver_top
    import wsfr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // input byte stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] byte_value
    input  logic        s_tuser,   // [0] stream_ended
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [7:0] out_byte, [10:8] error_code, [11] now_closed
    output logic [3:0]  m_tuser,   // [1:0] event_kind, [2] has_byte, [3] text_message
    output logic        m_tlast,   // ends_unit
    // configuration writes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    logic [31:0]  max_frame_reg;
    logic [31:0]  max_msg_reg;
    logic         out_valid_reg;
    wsfr_result_t out_res_reg;
    logic         advance;
    logic         res_valid;
    wsfr_result_t res;
    logic         closed;

    // the result register is free when empty or being taken this cycle
    assign s_tready  = !out_valid_reg || m_tready;
    assign advance   = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    wsfr_parse u_parse (
        .clk               (clk),
        .rst_n             (rst_n),
        .advance           (advance),
        .byte_value        (s_tdata),
        .stream_ended      (s_tuser),
        .max_frame_payload (max_frame_reg),
        .max_message_bytes (max_msg_reg),
        .res_valid         (res_valid),
        .res               (res),
        .closed            (closed)
    );

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_frame_reg <= MAX_FRAME_RESET;
            max_msg_reg   <= MAX_MESSAGE_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_MAX_FRAME:   max_frame_reg <= cfg_data;
                REG_MAX_MESSAGE: max_msg_reg   <= cfg_data;
                default:         ;
            endcase
        end
    end

    // result register valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= res_valid;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    // result payload, loaded on every accepted byte
    always_ff @(posedge clk)
    begin
        if (advance)
            out_res_reg <= res;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'd0, out_res_reg.now_closed, out_res_reg.error_code,
                       out_res_reg.out_byte};
    assign m_tuser  = {out_res_reg.text_message, out_res_reg.has_byte,
                       out_res_reg.event_kind};
    assign m_tlast  = out_res_reg.ends_unit;

    // a closed channel stays closed until reset
    a_closed_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        closed |=> closed)
        else $error("channel reopened without reset");

    // an error result carries a code and closes the channel
    a_error_closes: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && out_res_reg.event_kind == KIND_ERROR) |->
        (out_res_reg.now_closed && out_res_reg.error_code != ERR_NONE && closed))
        else $error("error result without code or close");

    // a held result blocks the input side
    a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |-> !s_tready)
        else $error("input taken while result is stalled");

    // a closed channel produces no further results
    a_closed_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (closed && advance) |=> !m_tvalid)
        else $error("result produced on closed channel");

endmodule
